### hdl/fifth_order_eso_control_step_assert.svh
// Assertion macros used by the controller module.
// Both macros expect clk and arst_n in the enclosing scope.
`ifndef FIFTH_ORDER_ESO_CONTROL_STEP_ASSERT_SVH
`define FIFTH_ORDER_ESO_CONTROL_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FOECS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FOECS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/foecs_pkg.sv
// Shared types, constants and microprogram for the fifth-order ESO control step.
// No dependencies; imported by the controller, datapath and top level.
package foecs_pkg;

	localparam int WORD_W    = 48;
	localparam int FRAC_BITS = 24;
	localparam int DRIVE_W   = 26;
	localparam int CFG_W     = 35;
	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W    = 5;
	localparam int PC_W      = 7;

	localparam logic [WORD_W-1:0] Q_ONE  = WORD_W'(1) << FRAC_BITS;
	localparam logic [WORD_W-1:0] Q_FIVE = WORD_W'(5) << FRAC_BITS;
	localparam logic [WORD_W-1:0] Q_TEN  = WORD_W'(10) << FRAC_BITS;
	localparam logic [WORD_W-1:0] W_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] W_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_OBW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CBW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SETP = 3'd4;

	// register file slots
	localparam logic [ADDR_W-1:0] A_Z0 = 5'd0;
	localparam logic [ADDR_W-1:0] A_Z1 = 5'd1;
	localparam logic [ADDR_W-1:0] A_Z2 = 5'd2;
	localparam logic [ADDR_W-1:0] A_Z3 = 5'd3;
	localparam logic [ADDR_W-1:0] A_Z4 = 5'd4;
	localparam logic [ADDR_W-1:0] A_U  = 5'd5;
	localparam logic [ADDR_W-1:0] A_Y  = 5'd6;
	localparam logic [ADDR_W-1:0] A_WO = 5'd7;
	localparam logic [ADDR_W-1:0] A_WC = 5'd8;
	localparam logic [ADDR_W-1:0] A_H  = 5'd9;
	localparam logic [ADDR_W-1:0] A_B  = 5'd10;
	localparam logic [ADDR_W-1:0] A_R  = 5'd11;
	localparam logic [ADDR_W-1:0] A_L0 = 5'd12;
	localparam logic [ADDR_W-1:0] A_L1 = 5'd13;
	localparam logic [ADDR_W-1:0] A_L2 = 5'd14;
	localparam logic [ADDR_W-1:0] A_L3 = 5'd15;
	localparam logic [ADDR_W-1:0] A_L4 = 5'd16;
	localparam logic [ADDR_W-1:0] A_K0 = 5'd17;
	localparam logic [ADDR_W-1:0] A_K1 = 5'd18;
	localparam logic [ADDR_W-1:0] A_K2 = 5'd19;
	localparam logic [ADDR_W-1:0] A_K3 = 5'd20;
	localparam logic [ADDR_W-1:0] A_K4 = 5'd21;
	localparam logic [ADDR_W-1:0] A_FV = 5'd22;
	localparam logic [ADDR_W-1:0] A_TN = 5'd23;
	localparam logic [ADDR_W-1:0] A_E  = 5'd24;
	localparam logic [ADDR_W-1:0] A_D0 = 5'd25;
	localparam logic [ADDR_W-1:0] A_D1 = 5'd26;
	localparam logic [ADDR_W-1:0] A_D2 = 5'd27;
	localparam logic [ADDR_W-1:0] A_D3 = 5'd28;
	localparam logic [ADDR_W-1:0] A_D4 = 5'd29;
	localparam logic [ADDR_W-1:0] A_T  = 5'd30;
	localparam logic [ADDR_W-1:0] A_W  = 5'd31;

	// constant selects for OP_LDC
	localparam logic [ADDR_W-1:0] C_ZERO = 5'd0;
	localparam logic [ADDR_W-1:0] C_OBW  = 5'd1;
	localparam logic [ADDR_W-1:0] C_CBW  = 5'd2;
	localparam logic [ADDR_W-1:0] C_STEP = 5'd3;
	localparam logic [ADDR_W-1:0] C_GAIN = 5'd4;
	localparam logic [ADDR_W-1:0] C_FIVE = 5'd5;
	localparam logic [ADDR_W-1:0] C_TEN  = 5'd6;
	localparam logic [ADDR_W-1:0] C_ONE  = 5'd7;

	// program entry points
	localparam logic [PC_W-1:0] PC_INIT = 7'd0;
	localparam logic [PC_W-1:0] PC_CTL  = 7'd13;
	localparam logic [PC_W-1:0] PC_OBS  = 7'd21;
	localparam logic [PC_W-1:0] PC_STEP = 7'd30;

	typedef enum logic [2:0] {
		OP_LDC, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_END, OP_OUT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] d;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
	} instr_t;

	typedef struct packed {
		logic   exec;
		logic   wb;
		logic   load_out;
		logic   ld_y;
		logic   cfg_wr;
		instr_t ins;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

	function automatic instr_t mk(op_t op, logic [ADDR_W-1:0] d, logic [ADDR_W-1:0] a,
		logic [ADDR_W-1:0] b);
		instr_t i;
		i.op = op;
		i.d  = d;
		i.a  = a;
		i.b  = b;
		return i;
	endfunction

	function automatic logic [WORD_W-1:0] const_val(logic [ADDR_W-1:0] c);
		logic [WORD_W-1:0] v;
		unique case (c)
			C_OBW:   v = WORD_W'(251658240);
			C_CBW:   v = WORD_W'(16777216);
			C_STEP:  v = WORD_W'(167772);
			C_GAIN:  v = WORD_W'(16777216);
			C_FIVE:  v = Q_FIVE;
			C_TEN:   v = Q_TEN;
			C_ONE:   v = Q_ONE;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic instr_t prog(logic [PC_W-1:0] pc);
		instr_t i;
		unique case (pc)
			// reset: clear state, load register defaults and constants
			7'd0:  i = mk(OP_LDC, A_Z0, C_ZERO, A_Z0);
			7'd1:  i = mk(OP_LDC, A_Z1, C_ZERO, A_Z0);
			7'd2:  i = mk(OP_LDC, A_Z2, C_ZERO, A_Z0);
			7'd3:  i = mk(OP_LDC, A_Z3, C_ZERO, A_Z0);
			7'd4:  i = mk(OP_LDC, A_Z4, C_ZERO, A_Z0);
			7'd5:  i = mk(OP_LDC, A_U,  C_ZERO, A_Z0);
			7'd6:  i = mk(OP_LDC, A_R,  C_ZERO, A_Z0);
			7'd7:  i = mk(OP_LDC, A_WO, C_OBW,  A_Z0);
			7'd8:  i = mk(OP_LDC, A_WC, C_CBW,  A_Z0);
			7'd9:  i = mk(OP_LDC, A_H,  C_STEP, A_Z0);
			7'd10: i = mk(OP_LDC, A_B,  C_GAIN, A_Z0);
			7'd11: i = mk(OP_LDC, A_FV, C_FIVE, A_Z0);
			7'd12: i = mk(OP_LDC, A_TN, C_TEN,  A_Z0);
			// controller gains
			7'd13: i = mk(OP_MUL, A_D0, A_WC, A_WC);
			7'd14: i = mk(OP_MUL, A_D1, A_D0, A_WC);
			7'd15: i = mk(OP_MUL, A_D2, A_D1, A_WC);
			7'd16: i = mk(OP_MUL, A_K0, A_D2, A_FV);
			7'd17: i = mk(OP_MUL, A_K1, A_D1, A_TN);
			7'd18: i = mk(OP_MUL, A_K2, A_D0, A_TN);
			7'd19: i = mk(OP_MUL, A_K3, A_WC, A_FV);
			7'd20: i = mk(OP_LDC, A_K4, C_ONE,  A_Z0);
			// observer gains
			7'd21: i = mk(OP_MUL, A_D0, A_WO, A_WO);
			7'd22: i = mk(OP_MUL, A_D1, A_D0, A_WO);
			7'd23: i = mk(OP_MUL, A_D2, A_D1, A_WO);
			7'd24: i = mk(OP_MUL, A_L4, A_D2, A_WO);
			7'd25: i = mk(OP_MUL, A_L0, A_WO, A_FV);
			7'd26: i = mk(OP_MUL, A_L1, A_D0, A_TN);
			7'd27: i = mk(OP_MUL, A_L2, A_D1, A_TN);
			7'd28: i = mk(OP_MUL, A_L3, A_D2, A_FV);
			7'd29: i = mk(OP_END, A_Z0, A_Z0, A_Z0);
			// one observer and control step
			7'd30: i = mk(OP_SUB, A_E,  A_Y,  A_Z0);
			7'd31: i = mk(OP_MUL, A_T,  A_L0, A_E);
			7'd32: i = mk(OP_ADD, A_D0, A_Z1, A_T);
			7'd33: i = mk(OP_MUL, A_T,  A_L1, A_E);
			7'd34: i = mk(OP_ADD, A_D1, A_Z2, A_T);
			7'd35: i = mk(OP_MUL, A_T,  A_L2, A_E);
			7'd36: i = mk(OP_ADD, A_D2, A_Z3, A_T);
			7'd37: i = mk(OP_MUL, A_T,  A_L3, A_E);
			7'd38: i = mk(OP_ADD, A_D3, A_Z4, A_T);
			7'd39: i = mk(OP_MUL, A_T,  A_B,  A_U);
			7'd40: i = mk(OP_ADD, A_D3, A_D3, A_T);
			7'd41: i = mk(OP_MUL, A_D4, A_L4, A_E);
			7'd42: i = mk(OP_MUL, A_T,  A_H,  A_D0);
			7'd43: i = mk(OP_ADD, A_Z0, A_Z0, A_T);
			7'd44: i = mk(OP_MUL, A_T,  A_H,  A_D1);
			7'd45: i = mk(OP_ADD, A_Z1, A_Z1, A_T);
			7'd46: i = mk(OP_MUL, A_T,  A_H,  A_D2);
			7'd47: i = mk(OP_ADD, A_Z2, A_Z2, A_T);
			7'd48: i = mk(OP_MUL, A_T,  A_H,  A_D3);
			7'd49: i = mk(OP_ADD, A_Z3, A_Z3, A_T);
			7'd50: i = mk(OP_MUL, A_T,  A_H,  A_D4);
			7'd51: i = mk(OP_ADD, A_Z4, A_Z4, A_T);
			7'd52: i = mk(OP_SUB, A_T,  A_R,  A_Z0);
			7'd53: i = mk(OP_MUL, A_W,  A_K0, A_T);
			7'd54: i = mk(OP_MUL, A_T,  A_K1, A_Z1);
			7'd55: i = mk(OP_SUB, A_W,  A_W,  A_T);
			7'd56: i = mk(OP_MUL, A_T,  A_K2, A_Z2);
			7'd57: i = mk(OP_SUB, A_W,  A_W,  A_T);
			7'd58: i = mk(OP_MUL, A_T,  A_K3, A_Z3);
			7'd59: i = mk(OP_SUB, A_W,  A_W,  A_T);
			7'd60: i = mk(OP_MUL, A_T,  A_K4, A_Z4);
			7'd61: i = mk(OP_SUB, A_W,  A_W,  A_T);
			7'd62: i = mk(OP_SUB, A_W,  A_W,  A_Z4);
			7'd63: i = mk(OP_DIV, A_U,  A_W,  A_B);
			7'd64: i = mk(OP_OUT, A_Z0, A_Z0, A_Z0);
			default: i = mk(OP_END, A_Z0, A_Z0, A_Z0);
		endcase
		return i;
	endfunction

endpackage

### hdl/foecs_ram.sv
// Generic register-file RAM: one write port, two registered read ports.
// No package dependency.
module foecs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### hdl/foecs_dp.sv
// Datapath: register file, saturating adder, iterative multiplier and divider,
// result registers. Depends on foecs_pkg and foecs_ram.
module foecs_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  foecs_pkg::cmd_t                      cmd,
	output foecs_pkg::status_t                   status,
	input  logic [foecs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [foecs_pkg::CFG_W-1:0]          cfg_data,
	input  logic signed [foecs_pkg::WORD_W-1:0]  measured_output,
	output logic signed [foecs_pkg::DRIVE_W-1:0] control_value,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_zero,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_one,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_two,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_three,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_disturbance
);
	import foecs_pkg::*;

	localparam int PW = 2 * WORD_W;
	localparam int DW = 16;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] ra, rb;
	logic [WORD_W-1:0] alu_res;
	logic [WORD_W:0]   sum;

	// multiplier
	logic              mbusy_q, mdone_q, mneg_q;
	logic [1:0]        mcnt_q;
	logic [WORD_W-1:0] ma_q, mb_q, mres_q;
	logic [PW-1:0]     acc_q;
	logic [DW-1:0]     digit;
	logic [WORD_W+DW-1:0] pp;
	logic [PW:0]       pmag, prod, rsum, qv;
	logic [WORD_W-1:0] mround;

	// divider
	logic              dbusy_q, ddone_q, dneg_q;
	logic [4:0]        dcnt_q;
	logic [30:0]       rem_q, db_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [WORD_W-1:0] dres_q, dmag;
	logic [31:0]       r2;
	logic [WORD_W-1:0] uq;

	logic [WORD_W-1:0] sh_q [6];

	foecs_ram #(.WIDTH(WORD_W), .DEPTH(32)) u_rf (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (cmd.ins.a),
		.raddr_b (cmd.ins.b),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	always_comb begin
		sum = (cmd.ins.op == OP_SUB) ? ({ra[WORD_W-1], ra} - {rb[WORD_W-1], rb})
			: ({ra[WORD_W-1], ra} + {rb[WORD_W-1], rb});
		if (cmd.ins.op == OP_LDC) begin
			alu_res = const_val(cmd.ins.a);
		end else if (sum[WORD_W] != sum[WORD_W-1]) begin
			alu_res = sum[WORD_W] ? W_MIN : W_MAX;
		end else begin
			alu_res = sum[WORD_W-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cmd.ins.d;
		wdata = alu_res;
		priority if (cmd.cfg_wr) begin
			we = 1'b1;
			unique case (cfg_index)
				REG_OBW: begin
					waddr = A_WO;
					wdata = {{(WORD_W-29){1'b0}}, cfg_data[28:0]};
				end
				REG_CBW: begin
					waddr = A_WC;
					wdata = {{(WORD_W-29){1'b0}}, cfg_data[28:0]};
				end
				REG_STEP: begin
					waddr = A_H;
					wdata = {{(WORD_W-25){1'b0}}, cfg_data[24:0]};
				end
				REG_GAIN: begin
					waddr = A_B;
					wdata = {{(WORD_W-31){1'b0}}, cfg_data[30:0]};
				end
				REG_SETP: begin
					waddr = A_R;
					wdata = {{(WORD_W-CFG_W){cfg_data[CFG_W-1]}}, cfg_data};
				end
				default: we = 1'b0;
			endcase
		end else if (cmd.ld_y) begin
			we    = 1'b1;
			waddr = A_Y;
			wdata = measured_output;
		end else if (cmd.exec && (cmd.ins.op == OP_LDC || cmd.ins.op == OP_ADD
			|| cmd.ins.op == OP_SUB)) begin
			we = 1'b1;
		end else if (cmd.wb) begin
			we    = 1'b1;
			wdata = (cmd.ins.op == OP_MUL) ? mres_q : dres_q;
		end
	end

	// multiplier: 48 x 16 partial product per cycle, then round and saturate
	always_comb begin
		unique case (mcnt_q)
			2'd0:    digit = mb_q[DW-1:0];
			2'd1:    digit = mb_q[2*DW-1:DW];
			2'd2:    digit = mb_q[3*DW-1:2*DW];
			default: digit = '0;
		endcase
		pp    = ma_q * digit;
		pmag  = {1'b0, acc_q};
		prod  = mneg_q ? (~pmag + 1'b1) : pmag;
		rsum  = prod + ((PW+1)'(1) << (FRAC_BITS - 1));
		qv    = $unsigned($signed(rsum) >>> FRAC_BITS);
		if (&qv[PW:WORD_W-1] || ~|qv[PW:WORD_W-1]) begin
			mround = qv[WORD_W-1:0];
		end else begin
			mround = qv[PW] ? W_MIN : W_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.exec && cmd.ins.op == OP_MUL) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && cmd.ins.op == OP_MUL) begin
			mneg_q <= ra[WORD_W-1] ^ rb[WORD_W-1];
			ma_q   <= ra[WORD_W-1] ? (~ra + 1'b1) : ra;
			mb_q   <= rb[WORD_W-1] ? (~rb + 1'b1) : rb;
			acc_q  <= '0;
		end else if (mbusy_q) begin
			if (mcnt_q == 2'd3) begin
				mres_q <= mround;
			end else begin
				acc_q <= acc_q + ({{(PW-WORD_W-DW){1'b0}}, pp} << {mcnt_q, 4'b0000});
			end
		end
	end

	// divider: restoring, one quotient bit per cycle
	always_comb begin
		dmag = ra[WORD_W-1] ? (~ra + 1'b1) : ra;
		r2   = {rem_q, 1'b0};
		uq   = {{(WORD_W-FRAC_BITS){1'b0}}, quo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.exec && cmd.ins.op == OP_DIV) begin
				dcnt_q <= '0;
				if (dmag == '0 || dmag >= {{(WORD_W-31){1'b0}}, rb[30:0]}) begin
					ddone_q <= 1'b1;
				end else begin
					dbusy_q <= 1'b1;
				end
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'(FRAC_BITS)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && cmd.ins.op == OP_DIV) begin
			dneg_q <= ra[WORD_W-1];
			db_q   <= rb[30:0];
			rem_q  <= dmag[30:0];
			quo_q  <= '0;
			if (dmag == '0) begin
				dres_q <= '0;
			end else if (dmag >= {{(WORD_W-31){1'b0}}, rb[30:0]}) begin
				dres_q <= ra[WORD_W-1] ? (~Q_ONE + 1'b1) : Q_ONE;
			end
		end else if (dbusy_q) begin
			if (dcnt_q == 5'(FRAC_BITS)) begin
				dres_q <= dneg_q ? (~uq + 1'b1) : uq;
			end else if (r2 >= {1'b0, db_q}) begin
				rem_q <= 31'(r2 - {1'b0, db_q});
				quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_q <= r2[30:0];
				quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	assign status.done = mdone_q | ddone_q;

	// track estimates and drive as they are written; copy them to the outputs on load_out
	always_ff @(posedge clk) begin
		if (we && waddr <= A_U) begin
			sh_q[waddr[2:0]] <= wdata;
		end
		if (cmd.load_out) begin
			estimate_zero        <= sh_q[0];
			estimate_one         <= sh_q[1];
			estimate_two         <= sh_q[2];
			estimate_three       <= sh_q[3];
			estimate_disturbance <= sh_q[4];
			control_value        <= sh_q[5][DRIVE_W-1:0];
		end
	end

endmodule

### hdl/foecs_ctrl.sv
// Controller: sequences the microprogram, owns the handshakes and result valid.
// Depends on foecs_pkg and the assertion macro header.
`include "fifth_order_eso_control_step_assert.svh"
module foecs_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            meas_valid,
	output logic                            meas_stall,
	output logic                            result_valid,
	input  logic                            result_stall,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [foecs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  foecs_pkg::status_t              status,
	output foecs_pkg::cmd_t                 cmd
);
	import foecs_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_WAIT, S_HOLD} state_t;

	state_t          state_q;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	logic            meas_acc, cfg_acc, out_free;

	assign meas_stall   = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE) && !meas_valid;
	assign meas_acc     = meas_valid && !meas_stall;
	assign cfg_acc      = cfg_valid && cfg_ready;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.ins      = prog(pc_q);
		cmd.exec     = (state_q == S_EXEC);
		cmd.wb       = (state_q == S_WAIT) && status.done;
		cmd.load_out = (state_q == S_HOLD) && out_free;
		cmd.ld_y     = meas_acc;
		cmd.cfg_wr   = cfg_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_READ;
			pc_q        <= PC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (meas_acc) begin
						pc_q    <= PC_STEP;
						state_q <= S_READ;
					end else if (cfg_acc && cfg_index == REG_OBW) begin
						pc_q    <= PC_OBS;
						state_q <= S_READ;
					end else if (cfg_acc && cfg_index == REG_CBW) begin
						pc_q    <= PC_CTL;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					unique case (cmd.ins.op)
						OP_MUL, OP_DIV: state_q <= S_WAIT;
						OP_END:         state_q <= S_IDLE;
						OP_OUT:         state_q <= S_HOLD;
						default: begin
							pc_q    <= pc_q + 7'd1;
							state_q <= S_READ;
						end
					endcase
				end
				S_WAIT: begin
					if (status.done) begin
						pc_q    <= pc_q + 7'd1;
						state_q <= S_READ;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FOECS_ASSERT_NOW(a_no_overwrite, (out_valid_q && result_stall), !cmd.load_out,
		"result overwritten while stalled")
	`FOECS_ASSERT_NEXT(a_step_entry, meas_acc, (pc_q == PC_STEP && state_q == S_READ),
		"item accepted without starting the step program")
	`FOECS_ASSERT_NOW(a_wait_unit, (state_q == S_WAIT),
		(cmd.ins.op == OP_MUL || cmd.ins.op == OP_DIV), "waiting on no arithmetic unit")

endmodule

### hdl/fifth_order_eso_control_step.sv
// Top level of the fifth-order ESO control step: controller plus datapath.
// Depends on foecs_pkg, foecs_ctrl, foecs_dp and foecs_ram.
//
// Channels: measurement in (meas_valid/meas_stall, measured_output), result out
// (result_valid/result_stall, control_value and five estimates), and a register
// write port (cfg_valid/cfg_ready, cfg_index, cfg_data).
// Each measurement runs a 35-instruction program on one shared iterative
// multiplier (48 x 16 bits a cycle) and a restoring divider (one quotient bit
// a cycle, with a short path when the quotient saturates or is zero); a new
// measurement is taken only after the program for the last one has ended.
// The multiplier, used for sixteen products per item, takes most of its time.
// A finished result sits in the output register; the next measurement is taken
// while it waits, and that item only holds at its own end if the receiver still
// stalls. Writing a bandwidth register recomputes its gains (for the controller
// bandwidth this also derives the observer gains again), during which meas_stall
// is high and cfg_ready low.
// After reset the block clears its estimates, loads the register defaults and
// derives both gain sets before taking its first item.
module fifth_order_eso_control_step (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 meas_valid,
	output logic                                 meas_stall,
	input  logic signed [foecs_pkg::WORD_W-1:0]  measured_output,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [foecs_pkg::DRIVE_W-1:0] control_value,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_zero,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_one,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_two,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_three,
	output logic signed [foecs_pkg::WORD_W-1:0]  estimate_disturbance,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [foecs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [foecs_pkg::CFG_W-1:0]          cfg_data
);
	import foecs_pkg::*;

	cmd_t    cmd;
	status_t status;

	foecs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.meas_valid   (meas_valid),
		.meas_stall   (meas_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.status       (status),
		.cmd          (cmd)
	);

	foecs_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.measured_output      (measured_output),
		.control_value        (control_value),
		.estimate_zero        (estimate_zero),
		.estimate_one         (estimate_one),
		.estimate_two         (estimate_two),
		.estimate_three       (estimate_three),
		.estimate_disturbance (estimate_disturbance)
	);

endmodule
